// ===== rtl/core/ctie_pkg.sv =====
`timescale 1ns / 1ps
package ctie_pkg;

  localparam int DW = 64;
  localparam int HL = DW / 2;
  localparam int HH = DW - HL;
  localparam int MUL_STAGES = 3;

  localparam logic [3:0] MODE_ADD  = 4'd0;
  localparam logic [3:0] MODE_SUB  = 4'd1;
  localparam logic [3:0] MODE_MUL  = 4'd2;
  localparam logic [3:0] MODE_DIV  = 4'd3;
  localparam logic [3:0] MODE_TNOT = 4'd4;
  localparam logic [3:0] MODE_TAND = 4'd5;
  localparam logic [3:0] MODE_TOR  = 4'd6;
  localparam logic [3:0] MODE_BNEG = 4'd7;
  localparam logic [3:0] MODE_BZRO = 4'd8;
  localparam logic [3:0] MODE_BPOS = 4'd9;

  localparam logic [1:0] TAG_NULL = 2'd0;
  localparam logic [1:0] TAG_INT  = 2'd1;
  localparam logic [1:0] TAG_TRIT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TYPE = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  typedef struct packed {
    logic [3:0]         mode;
    logic [1:0]         a_type;
    logic signed [63:0] a_payload;
    logic [1:0]         b_type;
    logic signed [63:0] b_payload;
  } op_t;

  typedef struct packed {
    logic [1:0]         result_type;
    logic signed [63:0] result_payload;
    logic [1:0]         status;
    logic               branch_taken;
  } res_t;

  typedef struct packed {
    res_t fixed;
    logic is_mul;
    logic is_div;
    logic neg;
  } side_t;

  typedef struct packed {
    logic          ovf;
    logic [DW-1:0] val;
  } mul_res_t;

  function automatic logic [63:0] sext_w(logic [DW-1:0] v);
    logic [63:0] r;
    r = {64{v[DW-1]}};
    r[DW-1:0] = v;
    return r;
  endfunction

endpackage

// ===== rtl/core/ctie_decode.sv =====
`timescale 1ns / 1ps
module ctie_decode (
  input  ctie_pkg::op_t       op,
  output ctie_pkg::side_t     side,
  output logic [ctie_pkg::DW-1:0] mag_a,
  output logic [ctie_pkg::DW-1:0] mag_b
);
  import ctie_pkg::*;

  logic [DW-1:0]     aw, bw, sum, dif;
  logic              sa, sb, int_ok, a_ok, b_ok, add_ovf, sub_ovf;
  logic signed [1:0] ta, tb, tr;

  function automatic logic [63:0] trit_pat(logic signed [1:0] t);
    return {{63{t[1]}}, t[1] | t[0]};
  endfunction

  function automatic logic signed [1:0] trit_of(logic [DW-1:0] v);
    return (v == '1) ? 2'sb11 : (v[0] ? 2'sb01 : 2'sb00);
  endfunction

  always_comb begin
    aw = op.a_payload[DW-1:0];
    bw = op.b_payload[DW-1:0];
    sa = aw[DW-1];
    sb = bw[DW-1];
    mag_a = sa ? (~aw + DW'(1)) : aw;
    mag_b = sb ? (~bw + DW'(1)) : bw;
    sum = aw + bw;
    dif = aw - bw;
    add_ovf = (sa == sb) && (sum[DW-1] != sa);
    sub_ovf = (sa != sb) && (dif[DW-1] != sa);
    int_ok = (op.a_type == TAG_INT) && (op.b_type == TAG_INT);
    a_ok = (op.a_type == TAG_TRIT) && (aw == '0 || aw == DW'(1) || aw == '1);
    b_ok = (op.b_type == TAG_TRIT) && (bw == '0 || bw == DW'(1) || bw == '1);
    ta = trit_of(aw);
    tb = trit_of(bw);
    tr = '0;
    side.fixed.result_type = TAG_NULL;
    side.fixed.result_payload = '0;
    side.fixed.status = ST_OK;
    side.fixed.branch_taken = 1'b0;
    side.is_mul = 1'b0;
    side.is_div = 1'b0;
    side.neg = sa ^ sb;
    unique case (op.mode) inside
      MODE_ADD, MODE_SUB: begin
        if (!int_ok) begin
          side.fixed.status = ST_TYPE;
        end else if ((op.mode == MODE_ADD) ? add_ovf : sub_ovf) begin
          side.fixed.status = ST_OVF;
        end else begin
          side.fixed.result_type = TAG_INT;
          side.fixed.result_payload = sext_w((op.mode == MODE_ADD) ? sum : dif);
        end
      end
      MODE_MUL: begin
        if (!int_ok) side.fixed.status = ST_TYPE;
        else side.is_mul = 1'b1;
      end
      MODE_DIV: begin
        if (!int_ok) side.fixed.status = ST_TYPE;
        else if (bw == '0) side.fixed.status = ST_DIV0;
        else side.is_div = 1'b1;
      end
      MODE_TNOT: begin
        if (!a_ok) begin
          side.fixed.status = ST_TYPE;
        end else begin
          tr = -ta;
          side.fixed.result_type = TAG_TRIT;
          side.fixed.result_payload = trit_pat(tr);
        end
      end
      MODE_TAND, MODE_TOR: begin
        if (!a_ok || !b_ok) begin
          side.fixed.status = ST_TYPE;
        end else begin
          if (op.mode == MODE_TAND) tr = (ta < tb) ? ta : tb;
          else tr = (ta > tb) ? ta : tb;
          side.fixed.result_type = TAG_TRIT;
          side.fixed.result_payload = trit_pat(tr);
        end
      end
      MODE_BNEG, MODE_BZRO, MODE_BPOS: begin
        if (!a_ok) begin
          side.fixed.status = ST_TYPE;
        end else begin
          side.fixed.branch_taken = ((op.mode == MODE_BNEG) && (ta < 0)) ||
                                    ((op.mode == MODE_BZRO) && (ta == 0)) ||
                                    ((op.mode == MODE_BPOS) && (ta > 0));
        end
      end
      default: side.fixed.status = ST_TYPE;
    endcase
  end

endmodule

// ===== rtl/core/ctie_mul.sv =====
`timescale 1ns / 1ps
module ctie_mul (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ctie_pkg::DW-1:0] x,
  input  logic [ctie_pkg::DW-1:0] y,
  input  logic                    neg,
  output ctie_pkg::mul_res_t      res
);
  import ctie_pkg::*;

  localparam int DLY = DW - MUL_STAGES;

  logic [2*HL-1:0]    ll;
  logic [HL+HH-1:0]   lh, hl;
  logic [2*HH-1:0]    hh;
  logic               neg1, neg2;
  logic [2*DW-1:0]    prod;
  logic               ovf_next;
  logic [DW-1:0]      val_next;
  mul_res_t           line [DLY+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ll   <= x[HL-1:0] * y[HL-1:0];
      lh   <= x[HL-1:0] * y[DW-1:HL];
      hl   <= x[DW-1:HL] * y[HL-1:0];
      hh   <= x[DW-1:HL] * y[DW-1:HL];
      neg1 <= neg;
      prod <= (2*DW)'(ll) + ((2*DW)'(lh) << HL) + ((2*DW)'(hl) << HL)
              + ((2*DW)'(hh) << (2*HL));
      neg2 <= neg1;
    end
  end

  always_comb begin
    if (neg2) ovf_next = (prod[2*DW-1:DW] != '0) ||
                         (prod[DW-1:0] > {1'b1, {(DW-1){1'b0}}});
    else ovf_next = (prod[2*DW-1:DW] != '0) || prod[DW-1];
    val_next = neg2 ? (~prod[DW-1:0] + DW'(1)) : prod[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= '{ovf: ovf_next, val: val_next};
      for (int i = 1; i <= DLY; i++) line[i] <= line[i-1];
    end
  end

  assign res = line[DLY];

endmodule

// ===== rtl/core/ctie_div.sv =====
`timescale 1ns / 1ps
module ctie_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ctie_pkg::DW-1:0] dividend,
  input  logic [ctie_pkg::DW-1:0] divisor,
  output logic [ctie_pkg::DW-1:0] quotient
);
  import ctie_pkg::*;

  logic [DW-1:0] rem [DW];
  logic [DW-1:0] nq  [DW];
  logic [DW-1:0] dv  [DW];

  for (genvar i = 0; i < DW; i++) begin : g_step
    logic [DW-1:0] rem_in, nq_in, dv_in;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = dividend;
      assign dv_in  = divisor;
    end else begin : g_rest
      assign rem_in = rem[i-1];
      assign nq_in  = nq[i-1];
      assign dv_in  = dv[i-1];
    end

    assign trial = {rem_in, nq_in[DW-1]};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? DW'(trial - {1'b0, dv_in}) : trial[DW-1:0];
        nq[i]  <= {nq_in[DW-2:0], ge};
        dv[i]  <= dv_in;
      end
    end
  end

  assign quotient = nq[DW-1];

endmodule

// ===== rtl/core/checked_int_trit_execute_unit.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake          | beat
// op      | in  | op_valid/op_stall  | op_t: mode, operand tags, payloads
// res     | out | res_valid/res_stall| res_t: type, payload, status, taken
// One beat per cycle unless the output stalls; a beat passes the decode
// register, DW divider steps and the output register, set by the divider.
// Every operation runs through the same pipeline, so order is kept.
// rst clears valid bits only. A stalled output freezes the whole pipeline
// and raises op_stall in the same cycle.
module checked_int_trit_execute_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_stall,
  input  ctie_pkg::op_t    op,
  output logic             res_valid,
  input  logic             res_stall,
  output ctie_pkg::res_t   res
);
  import ctie_pkg::*;

  logic          en;
  side_t         side_in, side_a;
  logic [DW-1:0] mag_a_in, mag_b_in, mag_a, mag_b;
  logic          valid_a;
  side_t         side_line [DW];
  logic [DW-1:0] valid_line;
  mul_res_t      mres;
  logic [DW-1:0] quot;
  side_t         side_z;
  res_t          res_next;

  assign en = !res_valid || !res_stall;
  assign op_stall = !en;

  ctie_decode u_dec (.op(op), .side(side_in), .mag_a(mag_a_in), .mag_b(mag_b_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_line <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      valid_a <= op_valid;
      valid_line <= {valid_line[DW-2:0], valid_a};
      res_valid <= valid_line[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a <= side_in;
      mag_a <= mag_a_in;
      mag_b <= mag_b_in;
      side_line[0] <= side_a;
      for (int i = 1; i < DW; i++) side_line[i] <= side_line[i-1];
      res <= res_next;
    end
  end

  ctie_mul u_mul (.clk(clk), .en(en), .x(mag_a), .y(mag_b), .neg(side_a.neg),
                  .res(mres));

  ctie_div u_div (.clk(clk), .en(en), .dividend(mag_a), .divisor(mag_b),
                  .quotient(quot));

  assign side_z = side_line[DW-1];

  always_comb begin
    res_next = side_z.fixed;
    if (side_z.is_mul) begin
      if (mres.ovf) res_next = '{TAG_NULL, '0, ST_OVF, 1'b0};
      else res_next = '{TAG_INT, sext_w(mres.val), ST_OK, 1'b0};
    end else if (side_z.is_div) begin
      if (!side_z.neg && quot[DW-1]) res_next = '{TAG_NULL, '0, ST_OVF, 1'b0};
      else res_next = '{TAG_INT,
                        sext_w(side_z.neg ? (~quot + DW'(1)) : quot),
                        ST_OK, 1'b0};
    end
  end

endmodule

// ===== rtl/core/ctie_checker.sv =====
`timescale 1ns / 1ps
module ctie_checker (
  input logic           clk,
  input logic           rst,
  input logic           op_valid,
  input logic           op_stall,
  input ctie_pkg::op_t  op,
  input logic           res_valid,
  input logic           res_stall,
  input ctie_pkg::res_t res
);
  import ctie_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    op_stall == (res_valid && res_stall))
    else $error("input stall does not follow output stall");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_OK |->
      res.result_type == TAG_NULL && res.result_payload == '0 && !res.branch_taken)
    else $error("error result not cleared");

  a_branch_null: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.branch_taken |->
      res.result_type == TAG_NULL && res.result_payload == '0 && res.status == ST_OK)
    else $error("taken branch carries a value");

  a_int_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_type == TAG_INT |-> res.status == ST_OK)
    else $error("int result with error status");

endmodule

bind checked_int_trit_execute_unit ctie_checker u_ctie_checker (
  .clk(clk), .rst(rst), .op_valid(op_valid), .op_stall(op_stall), .op(op),
  .res_valid(res_valid), .res_stall(res_stall), .res(res)
);
